// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/mexp_pkg.sv =====
// Types, microcode addresses and the control store for the modexp unit.
// No dependencies.
package mexp_pkg;

  localparam int FIELD_W = 64;
  localparam int UPC_W   = 4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    SU_NONE,
    SU_SQUARE,
    SU_MULT
  } setup_e;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_BRES,
    WB_ACC
  } wb_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_EBIT_CLR,
    JC_NOT_ELAST,
    JC_MOD_ZERO
  } jump_e;

  // Microcode addresses
  localparam upc_t UPC_IDLE  = 4'd0;
  localparam upc_t UPC_RED   = 4'd1;
  localparam upc_t UPC_BWB   = 4'd2;
  localparam upc_t UPC_SQSET = 4'd3;
  localparam upc_t UPC_SQ    = 4'd4;
  localparam upc_t UPC_SQWB  = 4'd5;
  localparam upc_t UPC_MUSET = 4'd6;
  localparam upc_t UPC_MU    = 4'd7;
  localparam upc_t UPC_MUWB  = 4'd8;
  localparam upc_t UPC_NEXT  = 4'd9;
  localparam upc_t UPC_DONE  = 4'd10;

  typedef struct packed {
    logic   wait_start;
    setup_e setup;
    logic   iterate;
    wb_e    wb;
    logic   shift_exp;
    logic   done;
    jump_e  jump;
    upc_t   target;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic mod_zero;
    logic iter_last;
    logic ebit;
    logic elast;
  } status_t;

  // Control store: one word per microcode step.
  function automatic ctl_t ucode_rom(upc_t upc);
    ctl_t c;
    c = '0;
    unique case (upc)
      UPC_IDLE: begin
        c.wait_start = 1'b1;
        c.jump       = JC_MOD_ZERO;
        c.target     = UPC_DONE;
      end
      UPC_RED:   c.iterate = 1'b1;
      UPC_BWB:   c.wb      = WB_BRES;
      UPC_SQSET: c.setup   = SU_SQUARE;
      UPC_SQ:    c.iterate = 1'b1;
      UPC_SQWB: begin
        c.wb     = WB_ACC;
        c.jump   = JC_EBIT_CLR;
        c.target = UPC_NEXT;
      end
      UPC_MUSET: c.setup   = SU_MULT;
      UPC_MU:    c.iterate = 1'b1;
      UPC_MUWB:  c.wb      = WB_ACC;
      UPC_NEXT: begin
        c.shift_exp = 1'b1;
        c.jump      = JC_NOT_ELAST;
        c.target    = UPC_SQSET;
      end
      UPC_DONE: begin
        c.done   = 1'b1;
        c.jump   = JC_ALWAYS;
        c.target = UPC_IDLE;
      end
      default: begin
        c.jump   = JC_ALWAYS;
        c.target = UPC_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== src/mexp_mulmod.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle while step_i is high, MSB first.
// Depends on nothing but its parameter.
module mexp_mulmod #(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     setup_i,
  input  logic [OPERAND_WIDTH-1:0] mpl_i,
  input  logic [OPERAND_WIDTH-1:0] addend_i,
  input  logic                     step_i,
  input  logic [OPERAND_WIDTH-1:0] mod_i,
  output logic [OPERAND_WIDTH-1:0] prod_o,
  output logic                     last_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);
  localparam int XW = W + 2;

  logic [W-1:0]  r_q, r_d, mpl_q, add_q;
  logic [CW-1:0] cnt_q;
  logic [XW-1:0] x, sub1, sub2, m1, m2;

  // 2r + bit*a stays below 3m, so at most two subtractions of m.
  always_comb begin
    m1   = {2'b00, mod_i};
    m2   = {1'b0, mod_i, 1'b0};
    x    = {1'b0, r_q, 1'b0} + (mpl_q[W-1] ? {2'b00, add_q} : '0);
    sub1 = x - m1;
    sub2 = x - m2;
    if (x >= m2) begin
      r_d = sub2[W-1:0];
    end else if (x >= m1) begin
      r_d = sub1[W-1:0];
    end else begin
      r_d = x[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (setup_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (setup_i) begin
      r_q   <= '0;
      mpl_q <= mpl_i;
      add_q <= addend_i;
    end else if (step_i) begin
      r_q   <= r_d;
      mpl_q <= {mpl_q[W-2:0], 1'b0};
    end
  end

  assign prod_o = r_q;
  assign last_o = (cnt_q == CW'(W - 1));

endmodule

// ===== src/mexp_seq.sv =====
// Microcode sequencer: step counter, control store lookup, jump logic.
// Depends on mexp_pkg.
module mexp_seq
  import mexp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctl_t    ctl_o
);

  upc_t upc_q, upc_d;
  ctl_t ctl;
  logic hold, taken;

  always_comb begin
    ctl  = ucode_rom(upc_q);
    hold = (ctl.wait_start && !status_i.start) ||
           (ctl.iterate && !status_i.iter_last);
    unique case (ctl.jump)
      JC_NEXT:      taken = 1'b0;
      JC_ALWAYS:    taken = 1'b1;
      JC_EBIT_CLR:  taken = !status_i.ebit;
      JC_NOT_ELAST: taken = !status_i.elast;
      JC_MOD_ZERO:  taken = status_i.mod_zero;
      default:      taken = 1'b0;
    endcase
    if (hold) begin
      upc_d = upc_q;
    end else if (taken) begin
      upc_d = ctl.target;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctl_o = ctl;

endmodule

// ===== src/modular_exponentiation_unit.sv =====
// Modexp unit: base^exponent mod modulus by left-to-right square-and-multiply.
// Each exponent bit takes a square step, plus a multiply step when the bit is set;
// for modulus 0 the idle step jumps straight to the done step.
// One item at a time: the next item is taken in the cycle after the result strobe.
// Reset clears the sequencer and the bit counters only; the result strobe cannot be stalled.
// Depends on mexp_pkg, mexp_seq, mexp_mulmod and assert_macros.svh.
`include "assert_macros.svh"

module modular_exponentiation_unit
  import mexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] base_i,
  input  logic [FIELD_W-1:0] exponent_i,
  input  logic [FIELD_W-1:0] modulus_i,
  output logic               done_o,
  output logic [FIELD_W-1:0] power_residue_o,
  output logic               residue_is_one_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  ctl_t          ctl;
  status_t       status;
  logic          load;
  logic          mul_setup;
  logic [W-1:0]  mpl, addend, prod;
  logic          iter_last;

  // Operand and result registers (payload, no reset; ecnt_q is reset)
  logic [W-1:0]  m_q;     // modulus
  logic [W-1:0]  e_q;     // exponent, shifted left one bit per exponent step
  logic [W-1:0]  bres_q;  // base reduced mod m
  logic [W-1:0]  acc_q;   // running power
  logic [CW-1:0] ecnt_q;  // exponent bit position, from the MSB

  // An item enters only in the idle microcode step.
  assign load = ctl.wait_start && start;
  assign busy = !ctl.wait_start;

  always_comb begin
    status.start     = start;
    status.mod_zero  = (modulus_i[W-1:0] == '0);
    status.iter_last = iter_last;
    status.ebit      = e_q[W-1];
    status.elast     = (ecnt_q == CW'(W - 1));
  end

  mexp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctl_o   (ctl)
  );

  // Multiplier operands: on load it reduces the base (1 * base mod m);
  // later it squares acc or multiplies acc by the reduced base.
  always_comb begin
    mul_setup = load || (ctl.setup != SU_NONE);
    if (load) begin
      mpl    = base_i[W-1:0];
      addend = W'(1);
    end else begin
      mpl    = acc_q;
      addend = (ctl.setup == SU_MULT) ? bres_q : acc_q;
    end
  end

  mexp_mulmod #(
    .OPERAND_WIDTH(W)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .setup_i (mul_setup),
    .mpl_i   (mpl),
    .addend_i(addend),
    .step_i  (ctl.iterate),
    .mod_i   (m_q),
    .prod_o  (prod),
    .last_o  (iter_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecnt_q <= '0;
    end else if (load) begin
      ecnt_q <= '0;
    end else if (ctl.shift_exp) begin
      ecnt_q <= ecnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_q <= modulus_i[W-1:0];
      e_q <= exponent_i[W-1:0];
      // 1 mod m: zero for modulus 0 or 1
      acc_q <= (modulus_i[W-1:1] == '0) ? '0 : W'(1);
    end else begin
      if (ctl.shift_exp) begin
        e_q <= {e_q[W-2:0], 1'b0};
      end
      case (ctl.wb)
        WB_BRES: bres_q <= prod;
        WB_ACC:  acc_q  <= prod;
        default: ;
      endcase
    end
  end

  assign done_o           = ctl.done;
  assign power_residue_o  = FIELD_W'(acc_q);
  assign residue_is_one_o = (acc_q == W'(1));

  // Assertions
  `ASSERT_NEXT(a_done_single, done_o, !done_o)
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ASSERT_IMPL(a_done_busy, done_o, busy)
  `ASSERT_IMPL(a_res_reduced, done_o && (m_q != '0), acc_q < m_q)
  `ASSERT_IMPL(a_iter_no_setup, ctl.iterate, !mul_setup)

endmodule
